[rtl/pid_velocity_loop_deadband_defines.svh]
// Assertion macros shared by the velocity loop RTL.
`ifndef PID_VELOCITY_LOOP_DEADBAND_DEFINES_SVH
`define PID_VELOCITY_LOOP_DEADBAND_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PVLD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvld assertion failed");

// Next-cycle implication, checked outside reset.
`define PVLD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvld assertion failed");

`endif

[rtl/pvld_pkg.sv]
// Types, constants and helpers for the velocity loop with deadband.
package pvld_pkg;

   localparam int DIV_W  = 40;   // divisor width: holds 20 times a 32-bit time
   localparam int QUOT_W = 64;

   localparam logic [23:0] PROP_GAIN_RST   = 24'd3276800;
   localparam logic [23:0] INTEG_GAIN_RST  = 24'd0;
   localparam logic [23:0] DERIV_GAIN_RST  = 24'd0;
   localparam logic [23:0] DEADBAND_RST    = 24'd13107;
   localparam logic [23:0] INTEG_ZONE_RST  = 24'd13107;
   localparam logic [30:0] INTEG_LIMIT_RST = 31'd6553600;
   localparam logic [14:0] DRIVE_LIMIT_RST = 15'd100;
   localparam logic [7:0]  TIMEOUT_RST     = 8'd4;

   localparam logic OP_SETPOINT = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN   = 3'd0,
      CSR_INTEG_GAIN  = 3'd1,
      CSR_DERIV_GAIN  = 3'd2,
      CSR_DEADBAND    = 3'd3,
      CSR_INTEG_ZONE  = 3'd4,
      CSR_INTEG_LIMIT = 3'd5,
      CSR_DRIVE_LIMIT = 3'd6,
      CSR_TIMEOUT     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] setpoint;
      logic signed [31:0] wheel_angle;
      logic [31:0]        elapsed_time;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic signed [31:0] velocity;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

[rtl/pvld_div.sv]
// Restoring divider, one quotient bit per cycle.
module pvld_div
   import pvld_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [QUOT_W-1:0]   dividend,
   input  logic [DIV_W-1:0]    divisor,
   output logic [QUOT_W-1:0]   quotient,
   output div_stat_type        status
);
   `include "pid_velocity_loop_deadband_defines.svh"

   localparam int CNT_W = $clog2(QUOT_W);

   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    shifted;
   logic [DIV_W+1:0]  trial;
   logic              fits;

   always_comb begin
      shifted = {rem_ff[DIV_W-1:0], quot_ff[QUOT_W-1]};
      trial   = {1'b0, shifted} - {2'b0, dsr_ff};
      fits    = !trial[DIV_W+1];
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[DIV_W:0] : shifted;
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient      = quot_ff;
   assign status.busy   = busy_ff;
   assign status.done   = done_ff;

   `PVLD_ASSERT_NXT(a_start_busy, clock, reset, start, busy_ff)
   `PVLD_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff)

endmodule

[rtl/pid_velocity_loop_deadband.sv]
// Velocity PID loop with deadband and integral zone, Q16.16, one shared divider and multiplier.
//
// Usage:
//  - req channel (valid/ready) carries one item: opcode 0 loads a new setpoint and restarts
//    the timeout count, giving no result; opcode 1 is a control tick giving one rsp item.
//  - rsp channel (valid/ready) returns the integer drive and the derived velocity.
//  - csr port writes one register per cycle with csr_wr_en; write only while idle.
// Timing:
//  - A setpoint item leaves the block idle; req_ready is high again on the next cycle.
//  - A tick runs one 64-step division for the velocity, then the PID through the shared
//    32x32 multiplier (registered operands and product, four products), then a second
//    64-step division for the derivative before the drive is formed.
//  - Once the timeout count is reached a tick skips the PID and returns the held drive.
//  - The divider, one quotient bit per cycle, sets the rate; one item is in work at a time.
// Stalls: the result waits in an output register; the next setpoint is still taken, and a
//  finished tick holds in its last state until the output register is free.
// Reset: registers return to their reset values, target, angle, integral, previous error,
//  tick count and held drive clear, and no result is pending.
module pid_velocity_loop_deadband
   import pvld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wr_data
);
   `include "pid_velocity_loop_deadband_defines.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_VWAIT, ST_VFIN, ST_ERR, ST_IMUL, ST_IACC, ST_PMUL, ST_PACC,
      ST_QMUL, ST_QACC, ST_DMUL, ST_DSTART, ST_DWAIT, ST_FIN, ST_DONE
   } state_type;

   // configuration
   logic [23:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff, deadband_ff, integ_zone_ff;
   logic [30:0] integ_limit_ff;
   logic [14:0] drive_limit_ff;
   logic [7:0]  timeout_ff;

   // loop state
   state_type          state_ff, state_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] last_angle_ff, last_angle_in;
   logic signed [31:0] integ_sum_ff, integ_sum_in;
   logic signed [31:0] prev_err_ff, prev_err_in;
   logic [7:0]         tick_count_ff, tick_count_in;
   logic signed [15:0] held_drive_ff, held_drive_in;

   // per-item work registers
   logic               neg_ff, neg_in;      // sign of angle change, later of error change
   logic [31:0]        el_ff, el_in;
   logic signed [31:0] vel_ff, vel_in;
   logic signed [31:0] err_ff, err_in;
   logic               izone_ff, izone_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [15:0] drv_ff, drv_in;
   logic [31:0]        mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [63:0]        prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // shared divider
   logic               div_start;
   logic [QUOT_W-1:0]  div_dividend, div_quot;
   logic [DIV_W-1:0]   div_divisor;
   div_stat_type       div_stat;

   // scratch
   logic               accept;
   logic [31:0]        el_fix;
   logic signed [32:0] diff, err_raw, de;
   logic [32:0]        diff_mag, err_mag33, de_mag;
   logic [DIV_W-1:0]   el_wide;
   logic signed [31:0] err_sat;
   logic signed [63:0] term, sum, lim, total_mag;
   logic [47:0]        whole;
   logic [14:0]        drv_mag;
   logic [7:0]         tick_next;

   pvld_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .status   (div_stat)
   );

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      last_angle_in = last_angle_ff;
      integ_sum_in  = integ_sum_ff;
      prev_err_in   = prev_err_ff;
      tick_count_in = tick_count_ff;
      held_drive_in = held_drive_ff;
      neg_in        = neg_ff;
      el_in         = el_ff;
      vel_in        = vel_ff;
      err_in        = err_ff;
      izone_in      = izone_ff;
      acc_in        = acc_ff;
      drv_in        = drv_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;

      // velocity division set-up: |angle change| << 16 over 20 * elapsed
      el_fix   = (req_data.elapsed_time == 32'd0) ? 32'd1 : req_data.elapsed_time;
      diff     = {req_data.wheel_angle[31], req_data.wheel_angle}
               - {last_angle_ff[31], last_angle_ff};
      diff_mag = diff[32] ? (~diff + 33'd1) : diff;
      el_wide  = {{(DIV_W-32){1'b0}}, el_fix};

      // error, deadband and zone
      err_raw   = {target_ff[31], target_ff} - {vel_ff[31], vel_ff};
      err_mag33 = err_raw[32] ? (~err_raw + 33'd1) : err_raw;
      err_sat   = (err_raw[32] != err_raw[31]) ?
                  (err_raw[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : err_raw[31:0];

      de        = {err_ff[31], err_ff} - {prev_err_ff[31], prev_err_ff};
      de_mag    = de[32] ? (~de + 33'd1) : de;

      // signed Q16 product term, truncated toward zero
      term      = {16'b0, prod_ff[63:16]};
      sum       = '0;
      lim       = {33'b0, integ_limit_ff};
      total_mag = acc_ff[63] ? -acc_ff : acc_ff;
      whole     = total_mag[63:16];
      drv_mag   = (whole > {33'b0, drive_limit_ff}) ? drive_limit_ff : whole[14:0];
      tick_next = tick_count_ff + 8'd1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_SETPOINT) begin
                  target_in     = req_data.setpoint;
                  tick_count_in = '0;
               end else begin
                  el_in         = el_fix;
                  neg_in        = diff[32];
                  last_angle_in = req_data.wheel_angle;
                  div_start     = 1'b1;
                  div_dividend  = {15'b0, diff_mag, 16'b0};
                  div_divisor   = (el_wide << 4) + (el_wide << 2);
                  state_in      = ST_VWAIT;
               end
            end
         end
         ST_VWAIT: begin
            if (div_stat.done) begin
               state_in = ST_VFIN;
            end
         end
         ST_VFIN: begin
            // saturate the signed quotient to 32 bits
            if (neg_ff) begin
               vel_in = (div_quot > 64'd2147483648) ? 32'sh8000_0000 : -div_quot[31:0];
            end else begin
               vel_in = (div_quot > 64'd2147483647) ? 32'sh7FFF_FFFF : div_quot[31:0];
            end
            if (tick_count_ff < timeout_ff) begin
               state_in = ST_ERR;
            end else begin
               drv_in   = held_drive_ff;
               state_in = ST_DONE;
            end
         end
         ST_ERR: begin
            err_in   = (err_mag33 < {9'b0, deadband_ff}) ? 32'sd0 : err_sat;
            izone_in = (err_mag33 < {9'b0, integ_zone_ff})
                     && !(err_mag33 < {9'b0, deadband_ff});
            mul_a_in = mag32((err_mag33 < {9'b0, deadband_ff}) ? 32'd0 : err_sat);
            mul_b_in = el_ff;
            state_in = ST_IMUL;
         end
         ST_IMUL: state_in = ST_IACC;
         ST_IACC: begin
            sum = {{32{integ_sum_ff[31]}}, integ_sum_ff} + (err_ff[31] ? -term : term);
            if (!izone_ff) begin
               integ_sum_in = '0;
            end else if (sum > lim) begin
               integ_sum_in = lim[31:0];
            end else if (sum < -lim) begin
               integ_sum_in = -lim[31:0];
            end else begin
               integ_sum_in = sum[31:0];
            end
            mul_a_in = mag32(err_ff);
            mul_b_in = {8'b0, prop_gain_ff};
            state_in = ST_PMUL;
         end
         ST_PMUL: state_in = ST_PACC;
         ST_PACC: begin
            acc_in   = err_ff[31] ? -term : term;
            mul_a_in = mag32(integ_sum_ff);
            mul_b_in = {8'b0, integ_gain_ff};
            state_in = ST_QMUL;
         end
         ST_QMUL: state_in = ST_QACC;
         ST_QACC: begin
            acc_in   = acc_ff + (integ_sum_ff[31] ? -term : term);
            neg_in   = de[32];
            mul_a_in = de_mag[31:0];
            mul_b_in = {8'b0, deriv_gain_ff};
            state_in = ST_DMUL;
         end
         ST_DMUL: state_in = ST_DSTART;
         ST_DSTART: begin
            div_start    = 1'b1;
            div_dividend = prod_ff;
            div_divisor  = {{(DIV_W-32){1'b0}}, el_ff};
            state_in     = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_stat.done) begin
               acc_in   = acc_ff - (neg_ff ? -$signed(div_quot) : $signed(div_quot));
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // truncate to integer, clamp, then apply the timeout
            prev_err_in   = err_ff;
            tick_count_in = tick_next;
            if (tick_next == timeout_ff) begin
               drv_in = '0;
            end else begin
               drv_in = acc_ff[63] ? -$signed({1'b0, drv_mag}) : $signed({1'b0, drv_mag});
            end
            held_drive_in = drv_in;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.drive    = drv_ff;
               rsp_data_in.velocity = vel_ff;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         target_ff      <= '0;
         last_angle_ff  <= '0;
         integ_sum_ff   <= '0;
         prev_err_ff    <= '0;
         tick_count_ff  <= '0;
         held_drive_ff  <= '0;
         prop_gain_ff   <= PROP_GAIN_RST;
         integ_gain_ff  <= INTEG_GAIN_RST;
         deriv_gain_ff  <= DERIV_GAIN_RST;
         deadband_ff    <= DEADBAND_RST;
         integ_zone_ff  <= INTEG_ZONE_RST;
         integ_limit_ff <= INTEG_LIMIT_RST;
         drive_limit_ff <= DRIVE_LIMIT_RST;
         timeout_ff     <= TIMEOUT_RST;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         target_ff     <= target_in;
         last_angle_ff <= last_angle_in;
         integ_sum_ff  <= integ_sum_in;
         prev_err_ff   <= prev_err_in;
         tick_count_ff <= tick_count_in;
         held_drive_ff <= held_drive_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_PROP_GAIN:   prop_gain_ff   <= csr_wr_data[23:0];
               CSR_INTEG_GAIN:  integ_gain_ff  <= csr_wr_data[23:0];
               CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_wr_data[23:0];
               CSR_DEADBAND:    deadband_ff    <= csr_wr_data[23:0];
               CSR_INTEG_ZONE:  integ_zone_ff  <= csr_wr_data[23:0];
               CSR_INTEG_LIMIT: integ_limit_ff <= csr_wr_data[30:0];
               CSR_DRIVE_LIMIT: drive_limit_ff <= csr_wr_data[14:0];
               CSR_TIMEOUT:     timeout_ff     <= csr_wr_data[7:0];
               default: ;
            endcase
         end
      end
      neg_ff      <= neg_in;
      el_ff       <= el_in;
      vel_ff      <= vel_in;
      err_ff      <= err_in;
      izone_ff    <= izone_in;
      acc_ff      <= acc_in;
      drv_ff      <= drv_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      prod_ff     <= mul_a_ff * mul_b_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PVLD_ASSERT_IMP(a_ready_div_quiet, clock, reset, req_ready, !div_stat.busy)
   `PVLD_ASSERT_IMP(a_wait_div_live, clock, reset,
      (state_ff == ST_VWAIT || state_ff == ST_DWAIT), (div_stat.busy || div_stat.done))
   `PVLD_ASSERT_NXT(a_rsp_from_done, clock, reset,
      (!rsp_valid_ff && state_ff != ST_DONE), !rsp_valid_ff)

endmodule
